FILE: rtl/assert_macros.svh
// assertion helpers used by the rtl back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge while out of reset
`define NTPN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication form of the above
`define NTPN_ASSERT_IMP(lbl, ante, cons, msg) \
	`NTPN_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: rtl/ntpn_pkg.sv
`default_nettype none
package ntpn_pkg;

	localparam int COORD_FRAC_BITS  = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	// 0.001 rounded to the coordinate format
	localparam int MARGIN_RESET     = ((1 << COORD_FRAC_BITS) + 500) / 1000;
	// quotient bits of one normal component divide
	localparam int NQ_BITS          = NORMAL_FRAC_BITS + 1;
	// numerator width of the normal divide
	localparam int NUM_W            = 31 + NORMAL_FRAC_BITS + 1;
	localparam int QDEPTH           = 2;
	localparam int QAW              = $clog2(QDEPTH);

	typedef logic signed [32:0] diff_t;

	// one classified triangle between front and back
	typedef struct packed {
		logic  skip;
		logic  last;
		diff_t e1x;
		diff_t e1y;
		diff_t e1z;
		diff_t e2x;
		diff_t e2y;
		diff_t e2z;
		diff_t dx;
		diff_t dy;
		diff_t dz;
	} tri_t;

	typedef enum logic [1:0] {
		REG_QUERY_X,
		REG_QUERY_Y,
		REG_QUERY_Z,
		REG_BOX_MARGIN
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_NORM,
		ST_SQ,
		ST_ROOT,
		ST_NDIV,
		ST_DOT,
		ST_DDIV,
		ST_UPD,
		ST_OUT
	} back_state_t;

endpackage
`default_nettype wire

FILE: rtl/ntpn_front.sv
`default_nettype none
module ntpn_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  v0_x,
	input  logic signed [31:0]  v0_y,
	input  logic signed [31:0]  v0_z,
	input  logic signed [31:0]  v1_x,
	input  logic signed [31:0]  v1_y,
	input  logic signed [31:0]  v1_z,
	input  logic signed [31:0]  v2_x,
	input  logic signed [31:0]  v2_y,
	input  logic signed [31:0]  v2_z,
	input  logic                last_triangle,
	output ntpn_pkg::tri_t      push_data,
	output logic                push_valid,
	input  logic                push_ready
);
	import ntpn_pkg::*;

	logic signed [31:0] qx_q, qy_q, qz_q;
	logic [15:0]        margin_q;
	logic               valid_s1;
	tri_t               tri_s1;
	tri_t               tri_d;
	logic               miss_x, miss_y, miss_z;

	function automatic logic box_miss(input logic signed [31:0] a, input logic signed [31:0] b,
		input logic signed [31:0] d, input logic signed [31:0] q, input logic [15:0] m);
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic signed [33:0] lo_m;
		logic signed [33:0] hi_m;
		logic signed [33:0] qw;
		lo = (a < b) ? a : b;
		hi = (a > b) ? a : b;
		if (d < lo) lo = d;
		if (d > hi) hi = d;
		lo_m = 34'(lo) - $signed({18'd0, m});
		hi_m = 34'(hi) + $signed({18'd0, m});
		qw   = 34'(q);
		return (lo_m > qw) || (hi_m < qw);
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q     <= '0;
			qy_q     <= '0;
			qz_q     <= '0;
			margin_q <= 16'(MARGIN_RESET);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_QUERY_X:    qx_q     <= cfg_data;
				REG_QUERY_Y:    qy_q     <= cfg_data;
				REG_QUERY_Z:    qz_q     <= cfg_data;
				REG_BOX_MARGIN: margin_q <= cfg_data[15:0];
			endcase
		end
	end

	always_comb begin
		miss_x        = box_miss(v0_x, v1_x, v2_x, qx_q, margin_q);
		miss_y        = box_miss(v0_y, v1_y, v2_y, qy_q, margin_q);
		miss_z        = box_miss(v0_z, v1_z, v2_z, qz_q, margin_q);
		tri_d.skip    = miss_x | miss_y | miss_z;
		tri_d.last    = last_triangle;
		tri_d.e1x     = 33'(v1_x) - 33'(v0_x);
		tri_d.e1y     = 33'(v1_y) - 33'(v0_y);
		tri_d.e1z     = 33'(v1_z) - 33'(v0_z);
		tri_d.e2x     = 33'(v2_x) - 33'(v0_x);
		tri_d.e2y     = 33'(v2_y) - 33'(v0_y);
		tri_d.e2z     = 33'(v2_z) - 33'(v0_z);
		tri_d.dx      = 33'(qx_q) - 33'(v0_x);
		tri_d.dy      = 33'(qy_q) - 33'(v0_y);
		tri_d.dz      = 33'(qz_q) - 33'(v0_z);
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = tri_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tri_s1 <= tri_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/ntpn_fifo.sv
`default_nettype none
module ntpn_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  ntpn_pkg::tri_t wr_data,
	input  logic           wr_valid,
	output logic           wr_ready,
	output ntpn_pkg::tri_t rd_data,
	output logic           rd_valid,
	input  logic           rd_ready
);
	import ntpn_pkg::*;

	tri_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;
	logic           do_wr, do_rd;

	assign wr_ready = cnt_q != (QAW+1)'(QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rd_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wr_q <= wr_q + 1'b1;
			if (do_rd) rd_q <= rd_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/ntpn_back.sv
`default_nettype none
`include "assert_macros.svh"
module ntpn_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ntpn_pkg::tri_t     pop_data,
	input  logic               pop_valid,
	output logic               pop_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic               found,
	output logic [31:0]        best_dist
);
	import ntpn_pkg::*;

	localparam logic [NQ_BITS-1:0] NORM_ONE = NQ_BITS'(1 << NORMAL_FRAC_BITS);

	back_state_t        st_q, st_d;
	logic [5:0]         cnt_q, cnt_d;
	logic [1:0]         k_q;
	tri_t               tri_q;
	logic               cand_q;
	logic signed [66:0] c0_q, c1_q, c2_q, dot_q;
	logic [66:0]        m0_q, m1_q, m2_q;
	logic [2:0]         sgn_q;
	logic [63:0]        sum_q, rn_q, res_q, bit_q;
	logic [31:0]        len_q, rem_q, dw_q, quo_q, dist_q;
	logic [15:0]        cn0_q, cn1_q, cn2_q;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_s1;
	logic [31:0]        best_d_q;
	logic [15:0]        bn0_q, bn1_q, bn2_q;
	logic               have_q;
	logic               out_valid_q, found_q;
	logic [15:0]        onx_q, ony_q, onz_q;
	logic [31:0]        odist_q;

	logic [66:0]        ormag;
	logic [6:0]         sh;
	logic               top_zero;
	logic [30:0]        s0, s1, s2;
	logic signed [31:0] cs0, cs1, cs2;
	logic [66:0]        mk;
	logic [NUM_W-1:0]   num;
	logic [32:0]        div_t;
	logic               div_ge;
	logic [31:0]        rem_n, quo_n;
	logic [63:0]        rt_sum, rn_n, res_n;
	logic               rt_ge;
	logic [66:0]        absdot;
	logic               dsat;
	logic [NQ_BITS-1:0] nq, ncap;
	logic signed [31:0] nsig;
	logic               better, out_load;

	// shared datapath helpers
	always_comb begin
		ormag    = m0_q | m1_q | m2_q;
		sh       = 7'd64 >> (cnt_q[2:0] - 3'd1);
		top_zero = (ormag >> (7'd67 - sh)) == 67'd0;
		s0       = m0_q[66:36];
		s1       = m1_q[66:36];
		s2       = m2_q[66:36];
		cs0      = sgn_q[0] ? -$signed({1'b0, s0}) : $signed({1'b0, s0});
		cs1      = sgn_q[1] ? -$signed({1'b0, s1}) : $signed({1'b0, s1});
		cs2      = sgn_q[2] ? -$signed({1'b0, s2}) : $signed({1'b0, s2});
		case (k_q)
			2'd0:    mk = m0_q;
			2'd1:    mk = m1_q;
			default: mk = m2_q;
		endcase
		num      = (NUM_W'(mk[66:36]) << NORMAL_FRAC_BITS) + NUM_W'(len_q >> 1);
		div_t    = {rem_q, dw_q[31]};
		div_ge   = div_t >= {1'b0, len_q};
		rem_n    = div_ge ? 32'(div_t - {1'b0, len_q}) : div_t[31:0];
		quo_n    = {quo_q[30:0], div_ge};
		rt_sum   = res_q + bit_q;
		rt_ge    = rn_q >= rt_sum;
		rn_n     = rt_ge ? rn_q - rt_sum : rn_q;
		res_n    = rt_ge ? (res_q >> 1) + bit_q : res_q >> 1;
		absdot   = dot_q[66] ? 67'(-dot_q) : 67'(dot_q);
		dsat     = absdot >= {3'd0, len_q, 32'd0};
		nq       = quo_n[NQ_BITS-1:0];
		ncap     = (nq > NORM_ONE) ? NORM_ONE : nq;
		nsig     = sgn_q[k_q] ? -$signed(32'(ncap)) : $signed(32'(ncap));
		better   = !have_q || (dist_q < best_d_q);
	end

	// next state
	always_comb begin
		st_d  = st_q;
		cnt_d = cnt_q + 6'd1;
		unique case (st_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (pop_valid) st_d = pop_data.skip ? ST_UPD : ST_MUL;
			end
			ST_MUL: begin
				if (cnt_q == 6'd6) begin
					st_d  = ST_NORM;
					cnt_d = '0;
				end
			end
			ST_NORM: begin
				if (cnt_q == 6'd1 && ormag == 67'd0) begin
					st_d  = ST_UPD;
					cnt_d = '0;
				end else if (cnt_q == 6'd7) begin
					st_d  = ST_SQ;
					cnt_d = '0;
				end
			end
			ST_SQ: begin
				if (cnt_q == 6'd3) begin
					st_d  = ST_ROOT;
					cnt_d = '0;
				end
			end
			ST_ROOT: begin
				if (cnt_q == 6'd32) begin
					st_d  = ST_NDIV;
					cnt_d = '0;
				end
			end
			ST_NDIV: begin
				if (cnt_q == 6'(NQ_BITS)) begin
					cnt_d = '0;
					if (k_q == 2'd2) st_d = ST_DOT;
				end
			end
			ST_DOT: begin
				if (cnt_q == 6'd3) begin
					st_d  = ST_DDIV;
					cnt_d = '0;
				end
			end
			ST_DDIV: begin
				if ((cnt_q == 6'd0 && dsat) || cnt_q == 6'd32) begin
					st_d  = ST_UPD;
					cnt_d = '0;
				end
			end
			ST_UPD: begin
				cnt_d = '0;
				st_d  = tri_q.last ? ST_OUT : ST_IDLE;
			end
			ST_OUT: begin
				cnt_d = '0;
				if (!out_valid_q || out_ready) st_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop_ready = st_q == ST_IDLE;
		out_load  = (st_q == ST_OUT) && (!out_valid_q || out_ready);
		mul_a     = '0;
		mul_b     = '0;
		unique case (st_q)
			ST_MUL: begin
				case (cnt_q)
					6'd0: begin mul_a = tri_q.e1y; mul_b = tri_q.e2z; end
					6'd1: begin mul_a = tri_q.e1z; mul_b = tri_q.e2y; end
					6'd2: begin mul_a = tri_q.e1z; mul_b = tri_q.e2x; end
					6'd3: begin mul_a = tri_q.e1x; mul_b = tri_q.e2z; end
					6'd4: begin mul_a = tri_q.e1x; mul_b = tri_q.e2y; end
					6'd5: begin mul_a = tri_q.e1y; mul_b = tri_q.e2x; end
					default: ;
				endcase
			end
			ST_SQ: begin
				case (cnt_q)
					6'd0: begin mul_a = $signed({2'b0, s0}); mul_b = $signed({2'b0, s0}); end
					6'd1: begin mul_a = $signed({2'b0, s1}); mul_b = $signed({2'b0, s1}); end
					6'd2: begin mul_a = $signed({2'b0, s2}); mul_b = $signed({2'b0, s2}); end
					default: ;
				endcase
			end
			ST_DOT: begin
				case (cnt_q)
					6'd0: begin mul_a = 33'(cs0); mul_b = tri_q.dx; end
					6'd1: begin mul_a = 33'(cs1); mul_b = tri_q.dy; end
					6'd2: begin mul_a = 33'(cs2); mul_b = tri_q.dz; end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// control and kept state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			k_q         <= '0;
			best_d_q    <= '1;
			bn0_q       <= '0;
			bn1_q       <= '0;
			bn2_q       <= '0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
			if (st_q == ST_IDLE) k_q <= '0;
			else if (st_q == ST_NDIV && cnt_q == 6'(NQ_BITS)) k_q <= k_q + 2'd1;
			if (st_q == ST_UPD && cand_q && better) begin
				best_d_q <= dist_q;
				bn0_q    <= cn0_q;
				bn1_q    <= cn1_q;
				bn2_q    <= cn2_q;
				have_q   <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				best_d_q    <= '1;
				bn0_q       <= '0;
				bn1_q       <= '0;
				bn2_q       <= '0;
				have_q      <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		unique case (st_q)
			ST_IDLE: begin
				if (pop_valid) begin
					tri_q  <= pop_data;
					c0_q   <= '0;
					c1_q   <= '0;
					c2_q   <= '0;
					dot_q  <= '0;
					sum_q  <= '0;
					cand_q <= 1'b0;
				end
			end
			ST_MUL: begin
				case (cnt_q)
					6'd1: c0_q <= c0_q + 67'(prod_s1);
					6'd2: c0_q <= c0_q - 67'(prod_s1);
					6'd3: c1_q <= c1_q + 67'(prod_s1);
					6'd4: c1_q <= c1_q - 67'(prod_s1);
					6'd5: c2_q <= c2_q + 67'(prod_s1);
					6'd6: c2_q <= c2_q - 67'(prod_s1);
					default: ;
				endcase
			end
			ST_NORM: begin
				if (cnt_q == 6'd0) begin
					m0_q  <= c0_q[66] ? 67'(-c0_q) : 67'(c0_q);
					m1_q  <= c1_q[66] ? 67'(-c1_q) : 67'(c1_q);
					m2_q  <= c2_q[66] ? 67'(-c2_q) : 67'(c2_q);
					sgn_q <= {c2_q[66], c1_q[66], c0_q[66]};
				end else if (top_zero) begin
					m0_q <= m0_q << sh;
					m1_q <= m1_q << sh;
					m2_q <= m2_q << sh;
				end
			end
			ST_SQ: begin
				if (cnt_q != 6'd0) sum_q <= sum_q + 64'(prod_s1);
			end
			ST_ROOT: begin
				if (cnt_q == 6'd0) begin
					rn_q  <= sum_q;
					res_q <= '0;
					bit_q <= 64'd1 << 62;
				end else begin
					rn_q  <= rn_n;
					res_q <= res_n;
					bit_q <= bit_q >> 2;
					if (cnt_q == 6'd32) len_q <= res_n[31:0];
				end
			end
			ST_NDIV: begin
				if (cnt_q == 6'd0) begin
					rem_q <= 32'(num >> NQ_BITS);
					dw_q  <= 32'(num[NQ_BITS-1:0]) << (32 - NQ_BITS);
					quo_q <= '0;
				end else begin
					rem_q <= rem_n;
					dw_q  <= dw_q << 1;
					quo_q <= quo_n;
					if (cnt_q == 6'(NQ_BITS)) begin
						case (k_q)
							2'd0:    cn0_q <= nsig[15:0];
							2'd1:    cn1_q <= nsig[15:0];
							default: cn2_q <= nsig[15:0];
						endcase
					end
				end
			end
			ST_DOT: begin
				if (cnt_q != 6'd0) dot_q <= dot_q + 67'(prod_s1);
			end
			ST_DDIV: begin
				if (cnt_q == 6'd0) begin
					rem_q <= absdot[63:32];
					dw_q  <= absdot[31:0];
					quo_q <= '0;
					if (dsat) begin
						dist_q <= '1;
						cand_q <= 1'b1;
					end
				end else begin
					rem_q <= rem_n;
					dw_q  <= dw_q << 1;
					quo_q <= quo_n;
					if (cnt_q == 6'd32) begin
						dist_q <= quo_n;
						cand_q <= 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (out_load) begin
			onx_q   <= bn0_q;
			ony_q   <= bn1_q;
			onz_q   <= bn2_q;
			found_q <= have_q;
			odist_q <= best_d_q;
		end
	end

	assign out_valid = out_valid_q;
	assign normal_x  = onx_q;
	assign normal_y  = ony_q;
	assign normal_z  = onz_q;
	assign found     = found_q;
	assign best_dist = odist_q;

	`NTPN_ASSERT_IMP(a_empty_best, !have_q, best_d_q == 32'hFFFF_FFFF, "empty best not at max")
	`NTPN_ASSERT_IMP(a_norm_top, st_q == ST_SQ, (m0_q[66] | m1_q[66] | m2_q[66]), "cross not normalized")
	`NTPN_ASSERT_IMP(a_div_rem, (st_q == ST_NDIV || st_q == ST_DDIV) && cnt_q != 6'd0, rem_q < len_q, "divider remainder overflow")

endmodule
`default_nettype wire

FILE: rtl/nearest_triangle_plane_normal.sv
// channel   | handshake                 | payload
// ----------+---------------------------+---------------------------------------------
// in        | in_valid / in_ready       | v0_x..v2_z (q15.16), last_triangle
// out       | out_valid / out_ready     | normal_x/y/z (q1.14), found, best_dist
// cfg       | cfg_we (no wait)          | cfg_index, cfg_data (query_x/y/z, box_margin)
//
// sequence: a triangle outside the widened box goes from idle straight to the update
//   state; a kept triangle runs the cross multiply, normalize, squares, the 32 step square
//   root, three normal divides on the one shared restoring divider, dot and distance divide
// reset: arst_n clears all control and the kept best at once, no clearing pass
// stalls: a two entry queue parts front and back, so requests flow while the back end
//   works until the queue fills; the result register holds until out_ready takes it
`default_nettype none
module nearest_triangle_plane_normal (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] v0_x,
	input  logic signed [31:0] v0_y,
	input  logic signed [31:0] v0_z,
	input  logic signed [31:0] v1_x,
	input  logic signed [31:0] v1_y,
	input  logic signed [31:0] v1_z,
	input  logic signed [31:0] v2_x,
	input  logic signed [31:0] v2_y,
	input  logic signed [31:0] v2_z,
	input  logic               last_triangle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic               found,
	output logic [31:0]        best_dist
);
	import ntpn_pkg::*;

	// front to queue
	tri_t fq_data;
	logic fq_valid, fq_ready;
	// queue to back
	tri_t qb_data;
	logic qb_valid, qb_ready;

	// box test, edges and query offsets; holds the configuration registers
	ntpn_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.v0_x          (v0_x),
		.v0_y          (v0_y),
		.v0_z          (v0_z),
		.v1_x          (v1_x),
		.v1_y          (v1_y),
		.v1_z          (v1_z),
		.v2_x          (v2_x),
		.v2_y          (v2_y),
		.v2_z          (v2_z),
		.last_triangle (last_triangle),
		.push_data     (fq_data),
		.push_valid    (fq_valid),
		.push_ready    (fq_ready)
	);

	// short queue so front and back stall independently
	ntpn_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (fq_data),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.rd_data  (qb_data),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready)
	);

	// cross product, normalize, root, divides, best tracking and result register
	ntpn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (qb_data),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.normal_x  (normal_x),
		.normal_y  (normal_y),
		.normal_z  (normal_z),
		.found     (found),
		.best_dist (best_dist)
	);

endmodule
`default_nettype wire
